// ===== hdl/oriented_box_support_point_defines.svh =====
// ---------------------------------------------------------------------------
// Oriented box support point: assertion macros
// Concurrent checks that run on clock and are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ORIENTED_BOX_SUPPORT_POINT_DEFINES_SVH
`define ORIENTED_BOX_SUPPORT_POINT_DEFINES_SVH

`ifndef ASSERT_OFF
`define OBSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define OBSP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define OBSP_ASSERT(label, prop, msg)
`define OBSP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== hdl/obsp_pkg.sv =====
// ---------------------------------------------------------------------------
// Oriented box support point package
// Register indexes, fixed field widths and default parameter values.
// ---------------------------------------------------------------------------
package obsp_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int DIR_WIDTH_DEF   = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int POS_W      = 32;
   localparam int HALF_W     = 31;

   // quaternion components, signed Q1.14
   localparam int QUAT_W  = 16;
   localparam int QPROD_W = 2 * QUAT_W;
   // rotation matrix entries at scale 2^28
   localparam int ROT_FRAC = 28;
   localparam int MAT_W    = QPROD_W + 2;

   // cycles from an orientation write until the matrix registers hold it
   localparam int SETTLE_CYCLES = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      IDX_POS_X  = 3'd0,
      IDX_POS_Y  = 3'd1,
      IDX_POS_Z  = 3'd2,
      IDX_HALF_X = 3'd3,
      IDX_HALF_Y = 3'd4,
      IDX_HALF_Z = 3'd5,
      IDX_ORIENT = 3'd6
   } csr_idx_type;

endpackage

// ===== hdl/oriented_box_support_point.sv =====
// ---------------------------------------------------------------------------
// Oriented box support point
// Support mapping of an oriented box for GJK/MPR queries, five stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Write the box center (index 0..2), half extents (3..5) and the unit
//   quaternion (6) on the csr_ port while no word is in flight. Then send
//   search directions on req_ and take support points from rsp_.
// Data path: a word accepted on req_ reaches rsp_tvalid through five
//   register stages (products of the direction, corner select, products of
//   the corner, sum and round, center add and saturate).
// Throughput: one word per cycle unless rsp_tready or a rebuild stalls it;
//   each stage holds one word and the 9 + 9 multipliers are fully pipelined.
// After reset and after every orientation write, req_tready stays low
//   while the rotation matrix is rebuilt from the quaternion.
// Reset clears the pipeline, puts the center and half extents at zero
//   and the orientation at identity.
// When rsp_tready is low the words close up behind the output register and
//   req_tready falls once all five stages are full; nothing is lost.
// ---------------------------------------------------------------------------
`include "oriented_box_support_point_defines.svh"

module oriented_box_support_point #(
   parameter int COORD_WIDTH = obsp_pkg::COORD_WIDTH_DEF,
   parameter int DIR_WIDTH   = obsp_pkg::DIR_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // csr write port
   input  logic                                        csr_we,
   input  logic [obsp_pkg::CSR_ADDR_W-1:0]             csr_addr,
   input  logic [obsp_pkg::CSR_DATA_W-1:0]             csr_wdata,
   // direction in
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // req_tdata: dir_x, dir_y, dir_z (lowest first), zero padded to bytes
   input  logic [((3*DIR_WIDTH+7)/8)*8-1:0]            req_tdata,
   // support point out
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // rsp_tdata: sup_x, sup_y, sup_z (lowest first), zero padded to bytes
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          rsp_tdata
);
   import obsp_pkg::*;

   localparam int NSTAGE  = 5;
   localparam int RSP_W   = ((3*COORD_WIDTH+7)/8)*8;
   localparam int LP_W    = MAT_W + DIR_WIDTH;       // matrix times direction
   localparam int LS_W    = LP_W + 2;                 // sum of three
   localparam int CP_W    = MAT_W + COORD_WIDTH;      // matrix times corner
   localparam int CS_W    = CP_W + 2;                 // sum of three
   localparam int OFF_W   = CS_W - ROT_FRAC;          // rounded offset
   localparam int RES_W   = OFF_W + 1;                // center plus offset
   localparam int SET_W   = $clog2(SETTLE_CYCLES + 1);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [POS_W-1:0]  pos_ff  [3];
   logic [HALF_W-1:0] half_ff [3];
   logic [CSR_DATA_W-1:0] orient_ff;
   logic [SET_W-1:0]  settle_ff, settle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]  <= '0;
            half_ff[i] <= '0;
         end
         orient_ff <= {QUAT_W'(16'h4000), {(3*QUAT_W){1'b0}}};
      end else if (csr_we) begin
         unique case (csr_addr)
            IDX_POS_X:  pos_ff[0]  <= csr_wdata[POS_W-1:0];
            IDX_POS_Y:  pos_ff[1]  <= csr_wdata[POS_W-1:0];
            IDX_POS_Z:  pos_ff[2]  <= csr_wdata[POS_W-1:0];
            IDX_HALF_X: half_ff[0] <= csr_wdata[HALF_W-1:0];
            IDX_HALF_Y: half_ff[1] <= csr_wdata[HALF_W-1:0];
            IDX_HALF_Z: half_ff[2] <= csr_wdata[HALF_W-1:0];
            IDX_ORIENT: orient_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      settle_in = settle_ff;
      if (csr_we && (csr_addr == IDX_ORIENT)) begin
         settle_in = SET_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SET_W'(SETTLE_CYCLES);
      end else begin
         settle_ff <= settle_in;
      end
   end

   // center and half extents at coordinate width
   logic signed [COORD_WIDTH-1:0] pos_c  [3];
   logic signed [COORD_WIDTH-1:0] half_c [3];

   generate
      for (genvar g = 0; g < 3; g++) begin : g_ext
         if (COORD_WIDTH <= POS_W) begin : g_narrow
            assign pos_c[g]  = $signed(pos_ff[g][COORD_WIDTH-1:0]);
            assign half_c[g] = $signed({1'b0, half_ff[g][COORD_WIDTH-2:0]});
         end else begin : g_wide
            assign pos_c[g]  = $signed({{(COORD_WIDTH-POS_W){1'b0}}, pos_ff[g]});
            assign half_c[g] = $signed({{(COORD_WIDTH-HALF_W){1'b0}}, half_ff[g]});
         end
      end
   endgenerate

   // ------------------------------------------------------------------
   // rotation matrix from the quaternion, two register steps
   // ------------------------------------------------------------------
   logic signed [QUAT_W-1:0]  qx, qy, qz, qw;
   logic signed [QPROD_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [QPROD_W-1:0] xw_ff, yw_ff, zw_ff;
   logic signed [MAT_W-1:0]   mat_ff [3][3];
   logic signed [MAT_W-1:0]   mat_in [3][3];

   assign qx = $signed(orient_ff[QUAT_W-1:0]);
   assign qy = $signed(orient_ff[2*QUAT_W-1:QUAT_W]);
   assign qz = $signed(orient_ff[3*QUAT_W-1:2*QUAT_W]);
   assign qw = $signed(orient_ff[4*QUAT_W-1:3*QUAT_W]);

   always_ff @(posedge clock) begin
      xx_ff <= qx * qx;
      yy_ff <= qy * qy;
      zz_ff <= qz * qz;
      xy_ff <= qx * qy;
      xz_ff <= qx * qz;
      yz_ff <= qy * qz;
      xw_ff <= qx * qw;
      yw_ff <= qy * qw;
      zw_ff <= qz * qw;
   end

   always_comb begin
      logic signed [MAT_W-1:0] one;
      one = MAT_W'(1) <<< ROT_FRAC;
      mat_in[0][0] = one - ((MAT_W'(yy_ff) + MAT_W'(zz_ff)) <<< 1);
      mat_in[0][1] = (MAT_W'(xy_ff) - MAT_W'(zw_ff)) <<< 1;
      mat_in[0][2] = (MAT_W'(xz_ff) + MAT_W'(yw_ff)) <<< 1;
      mat_in[1][0] = (MAT_W'(xy_ff) + MAT_W'(zw_ff)) <<< 1;
      mat_in[1][1] = one - ((MAT_W'(xx_ff) + MAT_W'(zz_ff)) <<< 1);
      mat_in[1][2] = (MAT_W'(yz_ff) - MAT_W'(xw_ff)) <<< 1;
      mat_in[2][0] = (MAT_W'(xz_ff) - MAT_W'(yw_ff)) <<< 1;
      mat_in[2][1] = (MAT_W'(yz_ff) + MAT_W'(xw_ff)) <<< 1;
      mat_in[2][2] = one - ((MAT_W'(xx_ff) + MAT_W'(yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   // ------------------------------------------------------------------
   // pipeline control: a stage loads when it is empty or its word moves on
   // ------------------------------------------------------------------
   logic [NSTAGE-1:0] stg_v_ff, stg_v_in, stg_rdy;
   logic              in_valid;

   assign in_valid = req_tvalid && (settle_ff == '0);

   always_comb begin
      stg_rdy[NSTAGE-1] = !stg_v_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stg_rdy[k] = !stg_v_ff[k] || stg_rdy[k+1];
      end
      stg_v_in[0] = stg_rdy[0] ? in_valid : stg_v_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         stg_v_in[k] = stg_rdy[k] ? stg_v_ff[k-1] : stg_v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= '0;
      end else begin
         stg_v_ff <= stg_v_in;
      end
   end

   assign req_tready = stg_rdy[0] && (settle_ff == '0);

   // stage 1: direction times matrix columns, lp[i][j] = m[j][i] * d[j]
   logic signed [DIR_WIDTH-1:0] dir [3];
   logic signed [LP_W-1:0]      lp_ff [3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dir[j] = $signed(req_tdata[j*DIR_WIDTH +: DIR_WIDTH]);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               lp_ff[i][j] <= mat_ff[j][i] * dir[j];
            end
         end
      end
   end

   // stage 2: sign of each local component picks the corner
   logic signed [COORD_WIDTH-1:0] crn_ff [3];
   logic signed [COORD_WIDTH-1:0] crn_in [3];

   always_comb begin
      logic signed [LS_W-1:0] loc;
      for (int i = 0; i < 3; i++) begin
         loc = LS_W'(lp_ff[i][0]) + LS_W'(lp_ff[i][1]) + LS_W'(lp_ff[i][2]);
         if (loc[LS_W-1]) begin
            crn_in[i] = -half_c[i];
         end else if (loc != '0) begin
            crn_in[i] = half_c[i];
         end else begin
            crn_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         crn_ff <= crn_in;
      end
   end

   // stage 3: corner back to world, cp[i][j] = m[i][j] * c[j]
   logic signed [CP_W-1:0] cp_ff [3][3];

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               cp_ff[i][j] <= mat_ff[i][j] * crn_ff[j];
            end
         end
      end
   end

   // stage 4: sum and round half up out of the 2^28 scale
   logic signed [OFF_W-1:0] off_ff [3];
   logic signed [OFF_W-1:0] off_in [3];

   always_comb begin
      logic signed [CS_W-1:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = CS_W'(cp_ff[i][0]) + CS_W'(cp_ff[i][1]) + CS_W'(cp_ff[i][2])
             + (CS_W'(1) <<< (ROT_FRAC - 1));
         off_in[i] = acc[CS_W-1:ROT_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         off_ff <= off_in;
      end
   end

   // stage 5: add the center and saturate, output register
   logic [COORD_WIDTH-1:0] sup_ff [3];
   logic [COORD_WIDTH-1:0] sup_in [3];

   always_comb begin
      logic signed [RES_W-1:0] res;
      for (int i = 0; i < 3; i++) begin
         res = RES_W'(pos_c[i]) + RES_W'(off_ff[i]);
         if (!res[RES_W-1] && (res[RES_W-2:COORD_WIDTH-1] != '0)) begin
            sup_in[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end else if (res[RES_W-1] && (res[RES_W-2:COORD_WIDTH-1] != '1)) begin
            sup_in[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            sup_in[i] = res[COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         sup_ff <= sup_in;
      end
   end

   assign rsp_tvalid = stg_v_ff[NSTAGE-1];
   assign rsp_tdata  = RSP_W'({sup_ff[2], sup_ff[1], sup_ff[0]});

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `OBSP_ASSERT(a_orient_settle, csr_we && (csr_addr == IDX_ORIENT) |=> !req_tready, "word accepted while the rotation matrix rebuilds")
   `OBSP_ASSERT(a_stage_hold, stg_v_ff[0] && !stg_rdy[1] |=> stg_v_ff[0] && $stable(lp_ff[0][0]), "stalled stage 1 word lost or changed")
   `OBSP_ASSERT(a_corner_pick, stg_v_ff[1] |-> (crn_ff[0] == half_c[0] || crn_ff[0] == -half_c[0] || crn_ff[0] == '0), "corner x is not a signed half extent")
   `OBSP_ASSERT(a_out_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "output word changed while stalled")

endmodule
